FILE: hdl/csa_pkg.sv
// Shared types and constants for the circular stack ALU unit.
package csa_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int WORD_W      = 32;
	localparam int KIND_W      = 4;
	localparam int DELAY_W     = 5;

	localparam logic [DELAY_W-1:0] DELAY_MIN   = 5'd4;
	localparam logic [DELAY_W-1:0] DELAY_MAX   = 5'd21;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 5'd15;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH     = 4'd0,
		K_DROP     = 4'd1,
		K_BACK     = 4'd2,
		K_DUP      = 4'd3,
		K_SWAP     = 4'd4,
		K_OVER     = 4'd5,
		K_ADD      = 4'd6,
		K_AND      = 4'd7,
		K_OR       = 4'd8,
		K_XOR      = 4'd9,
		K_INVERT   = 4'd10,
		K_NEGATE   = 4'd11,
		K_DOT      = 4'd12,
		K_SETDELAY = 4'd13
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_SWAP
	} state_t;

	typedef struct packed {
		logic load;
		logic read;
		logic exec;
		logic swap2;
	} csa_cmd_t;

	typedef struct packed {
		logic is_swap;
	} csa_status_t;

endpackage

FILE: hdl/csa_ctrl.sv
// Sequencer for the circular stack ALU: handshakes and step commands.
module csa_ctrl import csa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	output logic        res_valid,
	input  logic        res_stall,
	input  csa_status_t status,
	output csa_cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;
	logic   res_valid_q;
	logic   out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_nx = ST_READ;
			end
			ST_READ: state_nx = ST_EXEC;
			ST_EXEC: begin
				if (out_free) state_nx = status.is_swap ? ST_SWAP : ST_IDLE;
			end
			ST_SWAP: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				cmd.load  = cmd_valid;
			end
			ST_READ: cmd.read = 1'b1;
			ST_EXEC: cmd.exec = out_free;
			ST_SWAP: cmd.swap2 = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.exec) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

FILE: hdl/csa_dpath.sv
// Datapath for the circular stack ALU: stack store, pointer, ALU and result register.
module csa_dpath import csa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csa_cmd_t                  cmd,
	output csa_status_t               status,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [WORD_W-1:0]  literal,
	output logic signed [WORD_W-1:0]  top_value,
	output logic signed [WORD_W-1:0]  removed_value,
	output logic [DELAY_W-1:0]        delay_setting
);

	logic [WORD_W-1:0]  mem_q [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] wvalid_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [DELAY_W-1:0] delay_q;
	kind_t              kind_q;
	logic [WORD_W-1:0]  lit_q;
	logic [WORD_W-1:0]  rd_a_q;
	logic [WORD_W-1:0]  rd_b_q;
	logic               va_q;
	logic               vb_q;
	logic [WORD_W-1:0]  top_q;
	logic [WORD_W-1:0]  removed_q;
	logic [DELAY_W-1:0] delay_out_q;

	logic [PTR_W-1:0]   p_up;
	logic [PTR_W-1:0]   p_dn;
	logic [PTR_W-1:0]   rd_b_addr;
	logic [WORD_W-1:0]  a;
	logic [WORD_W-1:0]  b;
	logic [PTR_W-1:0]   ptr_nx;
	logic [DELAY_W-1:0] delay_nx;
	logic [WORD_W-1:0]  top_nx;
	logic [WORD_W-1:0]  removed_nx;
	logic               we1;
	logic [PTR_W-1:0]   waddr1;
	logic [WORD_W-1:0]  wdata1;
	logic               wr_en;
	logic [PTR_W-1:0]   wr_addr;
	logic [WORD_W-1:0]  wr_data;

	assign p_up = (ptr_q == PTR_W'(STACK_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign p_dn = (ptr_q == '0) ? PTR_W'(STACK_DEPTH - 1) : ptr_q - 1'b1;
	assign rd_b_addr = (kind_q == K_BACK) ? p_up : p_dn;

	assign a = va_q ? rd_a_q : '0;
	assign b = vb_q ? rd_b_q : '0;

	assign status.is_swap = (kind_q == K_SWAP);

	always_comb begin
		ptr_nx     = ptr_q;
		delay_nx   = delay_q;
		top_nx     = a;
		removed_nx = '0;
		we1        = 1'b0;
		waddr1     = ptr_q;
		wdata1     = a;
		case (kind_q)
			K_PUSH: begin
				ptr_nx = p_up;
				top_nx = lit_q;
				we1    = 1'b1;
				waddr1 = p_up;
				wdata1 = lit_q;
			end
			K_DROP, K_DOT: begin
				ptr_nx     = p_dn;
				top_nx     = b;
				removed_nx = a;
			end
			K_SETDELAY: begin
				ptr_nx     = p_dn;
				top_nx     = b;
				removed_nx = a;
				if (a[WORD_W-1] || a < WORD_W'(DELAY_MIN)) delay_nx = DELAY_MIN;
				else if (a > WORD_W'(DELAY_MAX)) delay_nx = DELAY_MAX;
				else delay_nx = a[DELAY_W-1:0];
			end
			K_BACK: begin
				ptr_nx = p_up;
				top_nx = b;
			end
			K_DUP: begin
				ptr_nx = p_up;
				we1    = 1'b1;
				waddr1 = p_up;
				wdata1 = a;
			end
			K_SWAP: begin
				top_nx = b;
				we1    = 1'b1;
				waddr1 = ptr_q;
				wdata1 = b;
			end
			K_OVER: begin
				ptr_nx = p_up;
				top_nx = b;
				we1    = 1'b1;
				waddr1 = p_up;
				wdata1 = b;
			end
			K_ADD, K_AND, K_OR, K_XOR: begin
				ptr_nx = p_dn;
				case (kind_q)
					K_ADD:   top_nx = a + b;
					K_AND:   top_nx = a & b;
					K_OR:    top_nx = a | b;
					default: top_nx = a ^ b;
				endcase
				we1    = 1'b1;
				waddr1 = p_dn;
				wdata1 = top_nx;
			end
			K_INVERT: begin
				top_nx = ~a;
				we1    = 1'b1;
				wdata1 = top_nx;
			end
			K_NEGATE: begin
				top_nx = '0 - a;
				we1    = 1'b1;
				wdata1 = top_nx;
			end
			default: begin
				top_nx = a;
			end
		endcase
	end

	assign wr_en   = (cmd.exec && we1) || cmd.swap2;
	assign wr_addr = cmd.swap2 ? p_dn : waddr1;
	assign wr_data = cmd.swap2 ? a : wdata1;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (cmd.read) begin
			rd_a_q <= mem_q[ptr_q];
			rd_b_q <= mem_q[rd_b_addr];
		end
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			lit_q  <= literal;
		end
		if (cmd.exec) begin
			top_q       <= top_nx;
			removed_q   <= removed_nx;
			delay_out_q <= delay_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			ptr_q    <= '0;
			delay_q  <= DELAY_RESET;
			va_q     <= 1'b0;
			vb_q     <= 1'b0;
		end else begin
			if (wr_en) wvalid_q[wr_addr] <= 1'b1;
			if (cmd.read) begin
				va_q <= wvalid_q[ptr_q];
				vb_q <= wvalid_q[rd_b_addr];
			end
			if (cmd.exec) begin
				ptr_q   <= ptr_nx;
				delay_q <= delay_nx;
			end
		end
	end

	assign top_value     = top_q;
	assign removed_value = removed_q;
	assign delay_setting = delay_out_q;

endmodule

FILE: hdl/circular_stack_alu_unit.sv
// Top level of the circular stack ALU unit: sequencer and datapath.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  cmd     | cmd_valid / cmd_stall | kind, literal
//  res     | res_valid / res_stall | top_value, removed_value, delay_setting
//
// An operation steps through load, store read and execute; swap adds a
// second store write step, as its two store writes share the single write port.
// The result sits in an output register, so a new transfer on cmd is taken
// while a result still waits; execute holds until that register is free.
// Reset clears the pointer, sets the delay to fifteen and marks every stack
// entry as zero through per-entry valid bits.
module circular_stack_alu_unit import csa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [WORD_W-1:0]  literal,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic signed [WORD_W-1:0]  top_value,
	output logic signed [WORD_W-1:0]  removed_value,
	output logic [DELAY_W-1:0]        delay_setting
);

	csa_cmd_t    cmd;
	csa_status_t status;

	csa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	csa_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.literal       (literal),
		.top_value     (top_value),
		.removed_value (removed_value),
		.delay_setting (delay_setting)
	);

endmodule

FILE: dv/circular_stack_alu_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the circular stack ALU unit: directed and random stack operations.
module circular_stack_alu_unit_test;
	import csa_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd14;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;
	localparam int IDLE_PCT    = 22;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 16;

	typedef struct packed {
		logic [WORD_W-1:0]  top;
		logic [WORD_W-1:0]  removed;
		logic [DELAY_W-1:0] delay;
	} stack_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	logic [KIND_W-1:0]        kind = '0;
	logic signed [WORD_W-1:0] literal = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic signed [WORD_W-1:0] top_value;
	logic signed [WORD_W-1:0] removed_value;
	logic [DELAY_W-1:0]       delay_setting;

	logic [WORD_W-1:0]  stack_copy [STACK_DEPTH];
	int                 top_idx;
	logic [DELAY_W-1:0] delay_copy;
	stack_result_t      results_due [$];
	int                 errors = 0;
	int                 quiet_cycles = 0;
	bit                 steady = 1'b0;

	circular_stack_alu_unit dut (.*);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		errors++;
	endtask

	function automatic void stack_put(input logic [WORD_W-1:0] w);
		top_idx = (top_idx + 1) % STACK_DEPTH;
		stack_copy[top_idx] = w;
	endfunction

	function automatic logic [WORD_W-1:0] stack_take();
		logic [WORD_W-1:0] w;
		w = stack_copy[top_idx];
		top_idx = (top_idx + STACK_DEPTH - 1) % STACK_DEPTH;
		return w;
	endfunction

	function automatic void apply_stack_op(input logic [KIND_W-1:0] op,
			input logic [WORD_W-1:0] lit);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] removed;
		stack_result_t     r;
		removed = '0;
		case (op)
		K_PUSH: stack_put(lit);
		K_DROP, K_DOT: removed = stack_take();
		K_BACK: top_idx = (top_idx + 1) % STACK_DEPTH;
		K_DUP: stack_put(stack_copy[top_idx]);
		K_SWAP: begin
			a = stack_take();
			b = stack_take();
			stack_put(a);
			stack_put(b);
		end
		K_OVER: begin
			a = stack_take();
			b = stack_take();
			stack_put(b);
			stack_put(a);
			stack_put(b);
		end
		K_ADD: begin
			a = stack_take();
			stack_copy[top_idx] = a + stack_copy[top_idx];
		end
		K_AND: begin
			a = stack_take();
			stack_copy[top_idx] = a & stack_copy[top_idx];
		end
		K_OR: begin
			a = stack_take();
			stack_copy[top_idx] = a | stack_copy[top_idx];
		end
		K_XOR: begin
			a = stack_take();
			stack_copy[top_idx] = a ^ stack_copy[top_idx];
		end
		K_INVERT: stack_copy[top_idx] = ~stack_copy[top_idx];
		K_NEGATE: stack_copy[top_idx] = -stack_copy[top_idx];
		K_SETDELAY: begin
			removed = stack_take();
			if (removed[WORD_W-1] || removed < DELAY_MIN)
				delay_copy = DELAY_MIN;
			else if (removed > DELAY_MAX)
				delay_copy = DELAY_MAX;
			else
				delay_copy = removed[DELAY_W-1:0];
		end
		default: ;
		endcase
		r.top = stack_copy[top_idx];
		r.removed = removed;
		r.delay = delay_copy;
		results_due.push_back(r);
	endfunction

	function automatic logic [WORD_W-1:0] pick_literal();
		case ($urandom_range(3))
		0: return $urandom_range(25);
		1: return -$urandom_range(8);
		2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
		default: return $urandom();
		endcase
	endfunction

	// Hold each transfer until taken; valid stays high into the next one unless a random idle gap drops it.
	task automatic issue_op(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] lit);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		kind <= op;
		literal <= lit;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		apply_stack_op(op, lit);
	endtask

	task automatic await_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_and_spare();
		issue_op(KIND_SPARE_LO, $urandom());
		issue_op(K_DROP, $urandom());
		issue_op(K_BACK, $urandom());
		issue_op(KIND_SPARE_HI, $urandom());
	endtask

	task automatic test_stack_moves();
		issue_op(K_PUSH, 32'h7fff_ffff);
		issue_op(K_PUSH, 32'h0000_0001);
		issue_op(K_DUP, $urandom());
		issue_op(K_SWAP, $urandom());
		issue_op(K_OVER, $urandom());
		issue_op(K_DROP, $urandom());
	endtask

	task automatic test_alu_ops();
		issue_op(K_ADD, $urandom());
		issue_op(K_PUSH, 32'h8000_0000);
		issue_op(K_NEGATE, $urandom());
		issue_op(K_PUSH, 32'hffff_ffff);
		issue_op(K_AND, $urandom());
		issue_op(K_OR, $urandom());
		issue_op(K_XOR, $urandom());
		issue_op(K_INVERT, $urandom());
		issue_op(K_DOT, $urandom());
	endtask

	task automatic test_delay_clamp();
		issue_op(K_PUSH, 32'h8000_0000);
		issue_op(K_SETDELAY, $urandom());
		issue_op(K_PUSH, 32'd22);
		issue_op(K_SETDELAY, $urandom());
		issue_op(K_PUSH, 32'd9);
		issue_op(K_SETDELAY, $urandom());
		issue_op(K_PUSH, 32'd3);
		issue_op(K_SETDELAY, $urandom());
	endtask

	task automatic test_random_mix();
		logic [KIND_W-1:0] op;
		for (int n = 0; n < 600; n++) begin
			op = ($urandom_range(99) < 25) ? K_PUSH : KIND_W'($urandom_range(15));
			issue_op(op, pick_literal());
			if (n % 200 == 199)
				await_results();
		end
	endtask

	task automatic test_wrap_runs();
		kind_t unwind [9] = '{K_DROP, K_BACK, K_DOT, K_SWAP, K_OVER, K_ADD, K_XOR,
			K_NEGATE, K_SETDELAY};
		repeat (12) begin
			repeat ($urandom_range(12, 8)) issue_op(K_PUSH, pick_literal());
			repeat ($urandom_range(10, 3)) issue_op(unwind[$urandom_range(8)], $urandom());
		end
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		repeat (250) issue_op(KIND_W'($urandom_range(15)), pick_literal());
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (results_due.size() == 0)
				report_mismatch($sformatf("unexpected result, top_value %h", top_value));
			else begin
				want = results_due.pop_front();
				if (top_value !== want.top)
					report_mismatch($sformatf("top_value %h, expected %h",
						top_value, want.top));
				if (removed_value !== want.removed)
					report_mismatch($sformatf("removed_value %h, expected %h",
						removed_value, want.removed));
				if (delay_setting !== want.delay)
					report_mismatch($sformatf("delay_setting %0d, expected %0d",
						delay_setting, want.delay));
			end
		end
		res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("circular_stack_alu_unit_test failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		foreach (stack_copy[i]) stack_copy[i] = '0;
		top_idx = 0;
		delay_copy = DELAY_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_spare();
		test_stack_moves();
		test_alu_ops();
		test_delay_clamp();
		test_random_mix();
		test_wrap_runs();
		test_steady_stream();
		await_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("circular_stack_alu_unit_test passed");
		else
			$display("circular_stack_alu_unit_test failed");
		$finish;
	end

endmodule

FILE: circular_stack_alu_unit.f
hdl/csa_pkg.sv
hdl/csa_ctrl.sv
hdl/csa_dpath.sv
hdl/circular_stack_alu_unit.sv
dv/circular_stack_alu_unit_test.sv
